@@ rtl/tst_pkg.sv @@
// Package for the TDMA slot timer: widths, action and mode codes,
// register indexes, reset values and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package tst_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int ACTION_WIDTH = 3;
    localparam int MODE_WIDTH = 2;
    localparam int CFG_INDEX_WIDTH = 3;

    // Action codes
    localparam logic [ACTION_WIDTH-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_SYNC  = 3'd3;
    localparam logic [ACTION_WIDTH-1:0] ACT_MODE  = 3'd4;

    // Communication modes
    localparam logic [MODE_WIDTH-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_PARENT_RX = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_CHILD_RX  = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_TX        = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOT_PERIOD    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RX_OFFSET      = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TX_OFFSET      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYNC_RX_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DISPLAY_START  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DISPLAY_CYCLE  = 3'd5;

    // Register reset values
    localparam logic [COUNT_WIDTH-1:0] RST_SLOT_PERIOD    = COUNT_WIDTH'(1000);
    localparam logic [COUNT_WIDTH-1:0] RST_RX_OFFSET      = COUNT_WIDTH'(100);
    localparam logic [COUNT_WIDTH-1:0] RST_TX_OFFSET      = COUNT_WIDTH'(200);
    localparam logic [COUNT_WIDTH-1:0] RST_SYNC_RX_OFFSET = COUNT_WIDTH'(300);
    localparam logic [COUNT_WIDTH-1:0] RST_DISPLAY_START  = COUNT_WIDTH'(50);
    localparam logic [COUNT_WIDTH-1:0] RST_DISPLAY_CYCLE  = COUNT_WIDTH'(250);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] slot_period;
        logic [COUNT_WIDTH-1:0] rx_offset;
        logic [COUNT_WIDTH-1:0] tx_offset;
        logic [COUNT_WIDTH-1:0] sync_rx_offset;
        logic [COUNT_WIDTH-1:0] display_start;
        logic [COUNT_WIDTH-1:0] display_cycle;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_WIDTH-1:0] action;
        logic [COUNT_WIDTH-1:0]  value;
        logic [MODE_WIDTH-1:0]   comm_mode;
    } request_t;

    typedef struct packed {
        logic                   slot_start;
        logic                   rx_start;
        logic                   tx_start;
        logic                   sync_rx_open;
        logic                   display_tick;
        logic [COUNT_WIDTH-1:0] count_now;
    } result_t;

endpackage

@@ rtl/tst_cfg_regs.sv @@
// Configuration register file of the TDMA slot timer.
// Depends on tst_pkg.
`timescale 1ns / 1ps

module tst_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [tst_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [tst_pkg::COUNT_WIDTH-1:0]    wr_data,
    output tst_pkg::cfg_t                      cfg
);

    tst_pkg::cfg_t cfg_reg;
    tst_pkg::cfg_t cfg_next;

    // Decode the write; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                tst_pkg::REG_SLOT_PERIOD:    cfg_next.slot_period    = wr_data;
                tst_pkg::REG_RX_OFFSET:      cfg_next.rx_offset      = wr_data;
                tst_pkg::REG_TX_OFFSET:      cfg_next.tx_offset      = wr_data;
                tst_pkg::REG_SYNC_RX_OFFSET: cfg_next.sync_rx_offset = wr_data;
                tst_pkg::REG_DISPLAY_START:  cfg_next.display_start  = wr_data;
                tst_pkg::REG_DISPLAY_CYCLE:  cfg_next.display_cycle  = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_period    <= tst_pkg::RST_SLOT_PERIOD;
            cfg_reg.rx_offset      <= tst_pkg::RST_RX_OFFSET;
            cfg_reg.tx_offset      <= tst_pkg::RST_TX_OFFSET;
            cfg_reg.sync_rx_offset <= tst_pkg::RST_SYNC_RX_OFFSET;
            cfg_reg.display_start  <= tst_pkg::RST_DISPLAY_START;
            cfg_reg.display_cycle  <= tst_pkg::RST_DISPLAY_CYCLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tst_engine.sv @@
// Slot timer state and the single-pass step logic for one request.
// Depends on tst_pkg.
`timescale 1ns / 1ps

module tst_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  tst_pkg::request_t req,
    input  tst_pkg::cfg_t     cfg,
    output tst_pkg::result_t  res
);

    localparam int W = tst_pkg::COUNT_WIDTH;

    logic [W-1:0] counter_reg,  counter_next;
    logic         running_reg,  running_next;
    logic [W-1:0] cur_period_reg, cur_period_next;
    logic [W-1:0] nxt_period_reg, nxt_period_next;
    logic [W-1:0] disp_cmp_reg, disp_cmp_next;
    logic         rx_en_reg,    rx_en_next;
    logic         tx_en_reg,    tx_en_next;
    logic         sync_en_reg,  sync_en_next;

    logic         wrap;
    logic [W-1:0] tick_count;
    logic [W-1:0] disp_base;
    logic         disp_hit;

    // Tick datapath: wrap or increment, then compare the new count
    assign wrap       = (counter_reg >= cur_period_reg);
    assign tick_count = wrap ? '0 : W'(counter_reg + W'(1));
    assign disp_base  = wrap ? cfg.display_start : disp_cmp_reg;
    assign disp_hit   = (tick_count == disp_base);

    always_comb
    begin
        counter_next    = counter_reg;
        running_next    = running_reg;
        cur_period_next = cur_period_reg;
        nxt_period_next = nxt_period_reg;
        disp_cmp_next   = disp_cmp_reg;
        rx_en_next      = rx_en_reg;
        tx_en_next      = tx_en_reg;
        sync_en_next    = sync_en_reg;
        res             = '0;

        unique case (req.action)
            tst_pkg::ACT_TICK:
            begin
                if (running_reg)
                begin
                    counter_next = tick_count;
                    if (wrap)
                    begin
                        cur_period_next = nxt_period_reg;
                        nxt_period_next = cfg.slot_period;
                    end
                    disp_cmp_next    = disp_hit ? W'(disp_base + cfg.display_cycle)
                                                : disp_base;
                    res.slot_start   = wrap;
                    res.rx_start     = rx_en_reg   && (tick_count == cfg.rx_offset);
                    res.tx_start     = tx_en_reg   && (tick_count == cfg.tx_offset);
                    res.sync_rx_open = sync_en_reg && (tick_count == cfg.sync_rx_offset);
                    res.display_tick = disp_hit;
                end
            end
            tst_pkg::ACT_START:
            begin
                counter_next = req.value;
                running_next = 1'b1;
            end
            tst_pkg::ACT_STOP:
            begin
                running_next    = 1'b0;
                counter_next    = '0;
                cur_period_next = cfg.slot_period;
            end
            tst_pkg::ACT_SYNC:
            begin
                // Drift correction: add (counter - expected) to the next period
                nxt_period_next = W'(nxt_period_reg + W'(counter_reg - req.value));
            end
            tst_pkg::ACT_MODE:
            begin
                rx_en_next   = (req.comm_mode == tst_pkg::MODE_PARENT_RX) ||
                               (req.comm_mode == tst_pkg::MODE_CHILD_RX);
                tx_en_next   = (req.comm_mode == tst_pkg::MODE_TX);
                sync_en_next = (req.comm_mode == tst_pkg::MODE_TX);
            end
            default:
            begin
                counter_next = counter_reg;
            end
        endcase

        res.count_now = counter_next;
    end

    // Commit state only when the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            running_reg    <= 1'b0;
            cur_period_reg <= tst_pkg::RST_SLOT_PERIOD;
            nxt_period_reg <= tst_pkg::RST_SLOT_PERIOD;
            disp_cmp_reg   <= tst_pkg::RST_DISPLAY_START;
            rx_en_reg      <= 1'b0;
            tx_en_reg      <= 1'b0;
            sync_en_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            counter_reg    <= counter_next;
            running_reg    <= running_next;
            cur_period_reg <= cur_period_next;
            nxt_period_reg <= nxt_period_next;
            disp_cmp_reg   <= disp_cmp_next;
            rx_en_reg      <= rx_en_next;
            tx_en_reg      <= tx_en_next;
            sync_en_reg    <= sync_en_next;
        end
    end

`ifndef ASSERT_OFF
    // A stopped timer holds its counter at zero unless a start follows
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && req.action == tst_pkg::ACT_STOP |=> !running_reg && counter_reg == '0)
        else $error("stop did not clear the counter");

    // Tick while stopped leaves the counter untouched
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && req.action == tst_pkg::ACT_TICK && !running_reg
        |=> $stable(counter_reg))
        else $error("counter moved while stopped");
`endif

endmodule

@@ rtl/tdma_slot_timer.sv @@
// Top level of the TDMA slot timer: request register, result register,
// handshakes and configuration port.
// Depends on tst_pkg, tst_cfg_regs and tst_engine.
`timescale 1ns / 1ps

// The timer takes one request (tick, start, stop, sync correction or mode)
// per clock cycle while in_ready is high and returns one result per
// request, in order. A request waits in the request register and its
// result moves into the result register at the edge where the result
// slot is free or draining; out_valid rises with it. The limiting path is
// the tick loop: counter compare against the current period, the increment
// and the offset and display compares, all combinational ahead of the
// state registers. A stalled result holds one more request in the request
// register before in_ready drops.
// Configuration writes are always ready; write only while the timer is idle.
module tdma_slot_timer (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tst_pkg::ACTION_WIDTH-1:0]   action,
    input  logic [tst_pkg::COUNT_WIDTH-1:0]    value,
    input  logic [tst_pkg::MODE_WIDTH-1:0]     comm_mode,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               slot_start,
    output logic                               rx_start,
    output logic                               tx_start,
    output logic                               sync_rx_open,
    output logic                               display_tick,
    output logic [tst_pkg::COUNT_WIDTH-1:0]    count_now,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tst_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tst_pkg::COUNT_WIDTH-1:0]    cfg_data
);

    tst_pkg::cfg_t     cfg;
    tst_pkg::request_t req_reg;
    tst_pkg::result_t  res;
    tst_pkg::result_t  res_reg;
    logic              req_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_accept;

    assign cfg_ready = 1'b1;

    tst_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move a request into the result slot when that slot is free or draining
    assign advance   = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    tst_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg.action    <= action;
            req_reg.value     <= value;
            req_reg.comm_mode <= comm_mode;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_start   = res_reg.slot_start;
    assign rx_start     = res_reg.rx_start;
    assign tx_start     = res_reg.tx_start;
    assign sync_rx_open = res_reg.sync_rx_open;
    assign display_tick = res_reg.display_tick;
    assign count_now    = res_reg.count_now;

`ifndef ASSERT_OFF
    // A slot start always comes with the counter back at zero
    a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.slot_start |-> res_reg.count_now == '0)
        else $error("slot start with nonzero count");

    // Input stalls only when both the request and result registers are full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> req_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

    // Anything but a tick raises no flag
    a_flags_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        advance && req_reg.action != tst_pkg::ACT_TICK
        |=> !(res_reg.slot_start || res_reg.rx_start || res_reg.tx_start ||
              res_reg.sync_rx_open || res_reg.display_tick))
        else $error("flag raised by a non-tick request");

    // An advancing request always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost on advance");
`endif

endmodule
